// ===== hw/rtl/char_frame_deframer_unstuffer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the character frame deframer
// Shared property forms: implication in the same cycle and in the next cycle.
// ----------------------------------------------------------------------------
`ifndef CHAR_FRAME_DEFRAMER_UNSTUFFER_MACROS_SVH
`define CHAR_FRAME_DEFRAMER_UNSTUFFER_MACROS_SVH

// The consequent must hold in the cycle where the antecedent holds.
`define CFDU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cfdu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CFDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cfdu: next-cycle check failed");

`endif

// ===== hw/rtl/cfdu_pkg.sv =====
// ----------------------------------------------------------------------------
// cfdu_pkg
// Types and constants shared by the deframer front end, queue and back end.
// ----------------------------------------------------------------------------
package cfdu_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_HEAD   = 2'd0;
    localparam logic [1:0] KIND_PAY    = 2'd1;
    localparam logic [1:0] KIND_CRC    = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_NO_SYN1 = 3'd1;
    localparam logic [2:0] ST_NO_SYN2 = 3'd2;
    localparam logic [2:0] ST_NO_SOH  = 3'd3;
    localparam logic [2:0] ST_NO_STX  = 3'd4;
    localparam logic [2:0] ST_TRUNC   = 3'd5;

    // Byte values of the marker letters.
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_Y = 8'h59;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_X = 8'h58;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_L = 8'h4C;

    // One request can release at most eight results, of which up to seven are bytes.
    localparam int LIST_LEN   = 8;
    localparam int LIST_IDX_W = 3;
    localparam int LIST_CNT_W = 4;

    localparam int HCNT_W = 7;

    localparam int QUEUE_DEPTH = 2;

    // One queued command: a run of bytes of one kind, then an optional status.
    typedef struct packed {
        logic [1:0]                     kind;
        logic [LIST_CNT_W-1:0]          n_bytes;
        logic [LIST_LEN-1:0][7:0]       bytes;
        logic                           has_status;
        logic [2:0]                     status;
    } t_cmd;

endpackage

// ===== hw/rtl/cfdu_front.sv =====
// ----------------------------------------------------------------------------
// cfdu_front
// Frame parser: tracks markers, header count, the ETX look-ahead and the
// DLEDLE unstuffing state, and turns each byte into at most one queued command.
// ----------------------------------------------------------------------------
`include "char_frame_deframer_unstuffer_macros.svh"

module cfdu_front
    import cfdu_pkg::*;
#(
    parameter int HEADER_BYTES = 88
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_stream_end,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam logic [2:0] PH_SYN1 = 3'd0;
    localparam logic [2:0] PH_SYN2 = 3'd1;
    localparam logic [2:0] PH_SOH  = 3'd2;
    localparam logic [2:0] PH_STX  = 3'd3;
    localparam logic [2:0] PH_HEAD = 3'd4;
    localparam logic [2:0] PH_PAY  = 3'd5;
    localparam logic [2:0] PH_CRC  = 3'd6;

    localparam int STUFF_LEN = 6;

    localparam logic [7:0] MARKER_TEXT [4][3] = '{
        '{CH_S, CH_Y, CH_N},
        '{CH_S, CH_Y, CH_N},
        '{CH_S, CH_O, CH_H},
        '{CH_S, CH_T, CH_X}
    };

    localparam logic [7:0] STUFF_TEXT [STUFF_LEN] = '{CH_D, CH_L, CH_E, CH_D, CH_L, CH_E};

    // Bytes released by one step of the unstuffer.
    typedef struct packed {
        logic [2:0]                 n;
        logic [2:0]                 u_next;
        logic [STUFF_LEN-1:0][7:0]  bytes;
    } t_feed;

    // The held bytes always equal a prefix of DLEDLE, so only the count is kept.
    function automatic t_feed f_feed(input logic [2:0] u_in, input logic [7:0] x);
        t_feed      f;
        logic [2:0] u;
        f = '0;
        u = (u_in > 3'd5) ? 3'd0 : u_in;
        if (x == STUFF_TEXT[u]) begin
            if (u == 3'd5) begin
                f.bytes[0] = CH_D;
                f.bytes[1] = CH_L;
                f.bytes[2] = CH_E;
                f.n        = 3'd3;
                f.u_next   = 3'd0;
            end else begin
                f.u_next = u + 3'd1;
            end
        end else begin
            // A broken match releases the held prefix; a D may start a new one.
            for (int i = 0; i < STUFF_LEN; i++) begin
                if (3'(i) < u) begin
                    f.bytes[i] = STUFF_TEXT[i];
                end
            end
            if (x == CH_D) begin
                f.n      = u;
                f.u_next = 3'd1;
            end else begin
                f.bytes[u] = x;
                f.n        = u + 3'd1;
                f.u_next   = 3'd0;
            end
        end
        return f;
    endfunction

    function automatic t_feed f_prefix(input logic [2:0] u_in);
        t_feed      f;
        logic [2:0] u;
        f = '0;
        u = (u_in > 3'd5) ? 3'd0 : u_in;
        for (int i = 0; i < STUFF_LEN; i++) begin
            if (3'(i) < u) begin
                f.bytes[i] = STUFF_TEXT[i];
            end
        end
        f.n = u;
        return f;
    endfunction

    function automatic t_feed f_one(input logic [7:0] b);
        t_feed f;
        f          = '0;
        f.bytes[0] = b;
        f.n        = 3'd1;
        return f;
    endfunction

    function automatic t_cmd f_append(input t_cmd c, input t_feed f);
        t_cmd                  r;
        logic [LIST_CNT_W-1:0] idx;
        r = c;
        for (int j = 0; j < STUFF_LEN; j++) begin
            idx = c.n_bytes + LIST_CNT_W'(j);
            if (3'(j) < f.n && idx < LIST_CNT_W'(LIST_LEN)) begin
                r.bytes[idx[LIST_IDX_W-1:0]] = f.bytes[j];
            end
        end
        r.n_bytes = c.n_bytes + LIST_CNT_W'(f.n);
        return r;
    endfunction

    logic [2:0]        r_phase, n_phase;
    logic [1:0]        r_mcnt,  n_mcnt;
    logic [HCNT_W-1:0] r_hcnt,  n_hcnt;
    logic [1:0]        r_ecnt,  n_ecnt;
    logic [2:0]        r_ucnt,  n_ucnt;

    logic [2:0]        ph;
    logic [1:0]        mc;
    logic [1:0]        m;
    logic [1:0]        k;
    logic [2:0]        u;
    logic [HCNT_W-1:0] hnext;
    t_feed             fd;
    t_cmd              cmd;
    logic              accept;

    always_comb begin
        cmd     = '0;
        fd      = '0;
        ph      = (r_phase > PH_CRC) ? PH_SYN1 : r_phase;
        mc      = (r_phase > PH_CRC) ? 2'd0 : r_mcnt;
        m       = (mc > 2'd2) ? 2'd0 : mc;
        k       = (r_ecnt > 2'd2) ? 2'd2 : r_ecnt;
        u       = r_ucnt;
        hnext   = r_hcnt + 1'b1;
        n_phase = ph;
        n_mcnt  = mc;
        n_hcnt  = r_hcnt;
        n_ecnt  = r_ecnt;
        n_ucnt  = r_ucnt;

        if (i_stream_end) begin
            if (!(ph == PH_SYN1 && mc == 2'd0)) begin
                cmd.kind = KIND_PAY;
                if (ph == PH_PAY) begin
                    // Unstuffer bytes leave first, then the partial ETX.
                    cmd = f_append(cmd, f_prefix(r_ucnt));
                    if (k != 2'd0) begin
                        cmd = f_append(cmd, f_one(CH_E));
                    end
                    if (k == 2'd2) begin
                        cmd = f_append(cmd, f_one(CH_T));
                    end
                end
                cmd.has_status = 1'b1;
                cmd.status     = ST_TRUNC;
            end
            n_phase = PH_SYN1;
            n_mcnt  = '0;
            n_hcnt  = '0;
            n_ecnt  = '0;
            n_ucnt  = '0;
        end else begin
            case (ph)
                PH_SYN1, PH_SYN2, PH_SOH, PH_STX: begin
                    if (i_in_byte == MARKER_TEXT[ph[1:0]][m]) begin
                        if (m == 2'd2) begin
                            n_mcnt = '0;
                            if (ph == PH_SOH) begin
                                n_phase = PH_HEAD;
                                n_hcnt  = '0;
                            end else if (ph == PH_STX) begin
                                n_phase = PH_PAY;
                                n_ecnt  = '0;
                                n_ucnt  = '0;
                            end else begin
                                n_phase = ph + 3'd1;
                            end
                        end else begin
                            n_mcnt = m + 2'd1;
                        end
                    end else begin
                        cmd.kind       = KIND_STATUS;
                        cmd.has_status = 1'b1;
                        cmd.status     = ph + 3'd1;
                        n_phase        = PH_SYN1;
                        n_mcnt         = '0;
                        n_hcnt         = '0;
                        n_ecnt         = '0;
                        n_ucnt         = '0;
                    end
                end
                PH_HEAD: begin
                    cmd.kind = KIND_HEAD;
                    cmd      = f_append(cmd, f_one(i_in_byte));
                    n_hcnt   = hnext;
                    if (hnext >= HCNT_W'(HEADER_BYTES)) begin
                        n_hcnt  = '0;
                        n_mcnt  = '0;
                        n_phase = PH_STX;
                    end
                end
                PH_PAY: begin
                    cmd.kind = KIND_PAY;
                    if (k == 2'd2 && i_in_byte == CH_X) begin
                        cmd     = f_append(cmd, f_prefix(r_ucnt));
                        n_ecnt  = '0;
                        n_ucnt  = '0;
                        n_phase = PH_CRC;
                    end else if ((k == 2'd0 && i_in_byte == CH_E) ||
                                 (k == 2'd1 && i_in_byte == CH_T)) begin
                        n_ecnt = k + 2'd1;
                    end else begin
                        // A partial ETX that did not complete is payload after all.
                        if (k != 2'd0) begin
                            fd  = f_feed(u, CH_E);
                            cmd = f_append(cmd, fd);
                            u   = fd.u_next;
                        end
                        if (k == 2'd2) begin
                            fd  = f_feed(u, CH_T);
                            cmd = f_append(cmd, fd);
                            u   = fd.u_next;
                        end
                        if (i_in_byte == CH_E) begin
                            n_ecnt = 2'd1;
                        end else begin
                            n_ecnt = '0;
                            fd     = f_feed(u, i_in_byte);
                            cmd    = f_append(cmd, fd);
                            u      = fd.u_next;
                        end
                        n_ucnt = u;
                    end
                end
                PH_CRC: begin
                    cmd.kind       = KIND_CRC;
                    cmd            = f_append(cmd, f_one(i_in_byte));
                    cmd.has_status = 1'b1;
                    cmd.status     = ST_DONE;
                    n_phase        = PH_SYN1;
                    n_mcnt         = '0;
                    n_hcnt         = '0;
                    n_ecnt         = '0;
                    n_ucnt         = '0;
                end
                default: begin
                    n_phase = PH_SYN1;
                    n_mcnt  = '0;
                end
            endcase
        end
    end

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (cmd.n_bytes != '0 || cmd.has_status);
    assign o_cmd   = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYN1;
            r_mcnt  <= '0;
            r_hcnt  <= '0;
            r_ecnt  <= '0;
            r_ucnt  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_mcnt  <= n_mcnt;
            r_hcnt  <= n_hcnt;
            r_ecnt  <= n_ecnt;
            r_ucnt  <= n_ucnt;
        end
    end

    `CFDU_ASSERT_IMPL(a_hold_counts_in_range, i_clk, i_rst_n, 1'b1, (r_ucnt <= 3'd5 && r_ecnt <= 2'd2))

endmodule

// ===== hw/rtl/cfdu_queue.sv =====
// ----------------------------------------------------------------------------
// cfdu_queue
// Short command queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
`include "char_frame_deframer_unstuffer_macros.svh"

module cfdu_queue
    import cfdu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] f_next_ptr(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= f_next_ptr(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= f_next_ptr(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    `CFDU_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, (!o_full || i_pop))
    `CFDU_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

// ===== hw/rtl/cfdu_back.sv =====
// ----------------------------------------------------------------------------
// cfdu_back
// Result sequencer: expands one queued command into its results, one per
// cycle while i_ready is high, and marks the final one.
// ----------------------------------------------------------------------------
`include "char_frame_deframer_unstuffer_macros.svh"

module cfdu_back
    import cfdu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_data,
    output logic [2:0] o_status,
    output logic       o_last
);

    logic                  r_busy;
    t_cmd                  r_cmd;
    logic [LIST_IDX_W-1:0] r_idx;

    logic [LIST_CNT_W-1:0] total;
    logic                  in_bytes;
    logic                  is_last;
    logic                  taken;
    logic                  load;

    assign total    = r_cmd.n_bytes + LIST_CNT_W'(r_cmd.has_status);
    assign in_bytes = (LIST_CNT_W'(r_idx) < r_cmd.n_bytes);
    assign is_last  = (LIST_CNT_W'(r_idx) == total - 1'b1);
    assign taken    = r_busy && i_ready;
    // The next command loads in the cycle the last result is taken.
    assign load     = (!r_busy || (taken && is_last)) && !i_empty;
    assign o_pop    = load;

    assign o_valid  = r_busy;
    assign o_kind   = in_bytes ? r_cmd.kind : KIND_STATUS;
    assign o_data   = in_bytes ? r_cmd.bytes[r_idx] : 8'd0;
    assign o_status = in_bytes ? ST_DONE : r_cmd.status;
    assign o_last   = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (taken && is_last) begin
            r_busy <= 1'b0;
        end else if (taken) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
    end

    `CFDU_ASSERT_IMPL(a_idx_in_range, i_clk, i_rst_n, r_busy, (LIST_CNT_W'(r_idx) < total))
    `CFDU_ASSERT_NEXT(a_chain_restarts, i_clk, i_rst_n, (taken && is_last && !i_empty), (r_busy && r_idx == '0))

endmodule

// ===== hw/rtl/char_frame_deframer_unstuffer.sv =====
// ----------------------------------------------------------------------------
// char_frame_deframer_unstuffer
// Character-oriented frame deframer with DLE unstuffing of the payload.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_ready   i_in_byte, i_stream_end
//   output   out        o_valid / i_ready   o_kind, o_data, o_status, o_last
//
// One byte is parsed per cycle while the two-entry command queue has room.
// A byte releases N results (N is 0 to 8), and the output port sends them
// at one result per cycle while i_ready is high.
// A byte's results pass through a queue entry and the sequencer's command register.
// Reset is synchronous and clears the parser state and the queue at once.
// An output stall fills the queue, after which o_ready drops.
// ----------------------------------------------------------------------------
module char_frame_deframer_unstuffer
    import cfdu_pkg::*;
#(
    parameter int HEADER_BYTES = 88
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_stream_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_data,
    output logic [2:0] o_status,
    output logic       o_last
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd head_cmd;

    cfdu_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .i_stream_end (i_stream_end),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_cmd        (front_cmd)
    );

    cfdu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    cfdu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_cmd    (head_cmd),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_kind   (o_kind),
        .o_data   (o_data),
        .o_status (o_status),
        .o_last   (o_last)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character frame deframer testbench
// Sends received bytes into the deframer, some as whole frames and some as
// cut, corrupted or noisy streams, and checks every result against a
// byte-level prediction of marker hunting, header pass-through, payload
// unstuffing and end-of-stream handling.
// ----------------------------------------------------------------------------
module testbench;

    import cfdu_pkg::*;

    localparam int HDR_BYTES   = 88;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RUN_ITEMS   = 500;

    typedef enum logic [2:0] {
        P_SYN1, P_SYN2, P_SOH, P_STX, P_HEAD, P_PAY, P_CRC
    } t_deframe_phase;

    typedef enum logic [1:0] {
        FRAME_WHOLE, FRAME_CUT, FRAME_BAD_MARKER
    } t_frame_fault;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] status;
        logic       last;
    } t_deframe_result;

    typedef struct packed {
        logic [7:0] value;
        logic       stream_end;
        logic       wait_drain;
    } t_rx_item;

    typedef logic [7:0] t_byte_q[$];

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_in_byte    = 8'h00;
    logic       i_stream_end = 1'b0;
    logic       i_ready      = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_data;
    logic [2:0] o_status;
    logic       o_last;

    // Deframer state as the bench sees it.
    t_deframe_phase phase_now   = P_SYN1;
    int             mark_cnt    = 0;
    int             hdr_cnt     = 0;
    logic [7:0]     etx_hold[2];
    int             etx_cnt     = 0;
    logic [7:0]     dle_hold[5];
    int             dle_cnt     = 0;

    t_deframe_result step_res[$];
    t_deframe_result frame_results_q[$];
    t_rx_item        rx_stream_q[$];
    t_rx_item        next_item;
    t_deframe_result want;

    int cycle_count   = 0;
    int sent_count    = 0;
    int seen_count    = 0;
    int total_items   = 0;
    int fail_count    = 0;
    int frames_closed = 0;
    int truncations   = 0;
    int marker_errors = 0;

    char_frame_deframer_unstuffer #(
        .HEADER_BYTES(HDR_BYTES)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_stream_end(i_stream_end),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_kind),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Prediction of the deframer
    // ------------------------------------------------------------------
    function automatic logic [7:0] marker_char(t_deframe_phase p, int idx);
        case (idx)
            0: return CH_S;
            1: return (p == P_SOH) ? CH_O : (p == P_STX) ? CH_T : CH_Y;
            default: return (p == P_SOH) ? CH_H : (p == P_STX) ? CH_X : CH_N;
        endcase
    endfunction

    function automatic logic [7:0] dle_char(int idx);
        case (idx % 3)
            0: return CH_D;
            1: return CH_L;
            default: return CH_E;
        endcase
    endfunction

    function automatic void emit(logic [1:0] kind, logic [7:0] data, logic [2:0] st);
        t_deframe_result r;
        r = '{kind: kind, data: data, status: st, last: 1'b0};
        if (step_res.size() < LIST_LEN) begin
            step_res.push_back(r);
        end
    endfunction

    function automatic void clear_deframer();
        phase_now = P_SYN1;
        mark_cnt  = 0;
        hdr_cnt   = 0;
        etx_cnt   = 0;
        dle_cnt   = 0;
    endfunction

    function automatic void flush_unstuffer();
        for (int i = 0; i < dle_cnt; i++) begin
            emit(KIND_PAY, dle_hold[i], ST_DONE);
        end
        dle_cnt = 0;
    endfunction

    // On a broken DLEDLE run the first held byte goes out and the rest are
    // rescanned from the start, together with the byte that broke the run.
    function automatic void feed_unstuffer(logic [7:0] b);
        t_byte_q    work;
        t_byte_q    rest;
        logic [7:0] x;
        int         u;
        work.push_back(b);
        while (work.size() > 0) begin
            x = work.pop_front();
            u = dle_cnt;
            if (x == dle_char(u)) begin
                if (u == 5) begin
                    emit(KIND_PAY, CH_D, ST_DONE);
                    emit(KIND_PAY, CH_L, ST_DONE);
                    emit(KIND_PAY, CH_E, ST_DONE);
                    dle_cnt = 0;
                end else begin
                    dle_hold[u] = x;
                    dle_cnt = u + 1;
                end
            end else if (u == 0) begin
                emit(KIND_PAY, x, ST_DONE);
            end else begin
                emit(KIND_PAY, dle_hold[0], ST_DONE);
                rest = work;
                work = {};
                for (int i = 1; i < u; i++) begin
                    work.push_back(dle_hold[i]);
                end
                work.push_back(x);
                foreach (rest[i]) begin
                    work.push_back(rest[i]);
                end
                dle_cnt = 0;
            end
        end
    endfunction

    function automatic void payload_byte(logic [7:0] b);
        int k;
        k = etx_cnt;
        if (k == 2 && b == CH_X) begin
            etx_cnt = 0;
            flush_unstuffer();
            phase_now = P_CRC;
        end else if ((k == 0 && b == CH_E) || (k == 1 && b == CH_T)) begin
            etx_hold[k] = b;
            etx_cnt = k + 1;
        end else begin
            for (int i = 0; i < k; i++) begin
                feed_unstuffer(etx_hold[i]);
            end
            etx_cnt = 0;
            if (b == CH_E) begin
                etx_hold[0] = b;
                etx_cnt = 1;
            end else begin
                feed_unstuffer(b);
            end
        end
    endfunction

    function automatic void deframe_byte(logic [7:0] b, logic se);
        int              k;
        t_deframe_result r;
        step_res = {};
        if (se) begin
            if (!(phase_now == P_SYN1 && mark_cnt == 0)) begin
                if (phase_now == P_PAY) begin
                    k = etx_cnt;
                    flush_unstuffer();
                    for (int i = 0; i < k; i++) begin
                        emit(KIND_PAY, etx_hold[i], ST_DONE);
                    end
                end
                emit(KIND_STATUS, 8'h00, ST_TRUNC);
                truncations++;
            end
            clear_deframer();
        end else if (phase_now <= P_STX) begin
            if (b == marker_char(phase_now, mark_cnt)) begin
                if (mark_cnt == 2) begin
                    mark_cnt = 0;
                    case (phase_now)
                        P_SYN1: phase_now = P_SYN2;
                        P_SYN2: phase_now = P_SOH;
                        P_SOH: begin
                            phase_now = P_HEAD;
                            hdr_cnt = 0;
                        end
                        default: begin
                            phase_now = P_PAY;
                            etx_cnt = 0;
                            dle_cnt = 0;
                        end
                    endcase
                end else begin
                    mark_cnt++;
                end
            end else begin
                case (phase_now)
                    P_SYN1:  emit(KIND_STATUS, 8'h00, ST_NO_SYN1);
                    P_SYN2:  emit(KIND_STATUS, 8'h00, ST_NO_SYN2);
                    P_SOH:   emit(KIND_STATUS, 8'h00, ST_NO_SOH);
                    default: emit(KIND_STATUS, 8'h00, ST_NO_STX);
                endcase
                marker_errors++;
                clear_deframer();
            end
        end else if (phase_now == P_HEAD) begin
            emit(KIND_HEAD, b, ST_DONE);
            hdr_cnt = (hdr_cnt + 1) & 127;
            if (hdr_cnt >= HDR_BYTES) begin
                hdr_cnt = 0;
                mark_cnt = 0;
                phase_now = P_STX;
            end
        end else if (phase_now == P_PAY) begin
            payload_byte(b);
        end else begin
            emit(KIND_CRC, b, ST_DONE);
            emit(KIND_STATUS, 8'h00, ST_DONE);
            frames_closed++;
            clear_deframer();
        end
        foreach (step_res[i]) begin
            r = step_res[i];
            r.last = (i == step_res.size() - 1);
            frame_results_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic void queue_item(logic [7:0] v, logic se, logic drain);
        rx_stream_q.push_back('{value: v, stream_end: se, wait_drain: drain});
    endfunction

    function automatic t_byte_q rand_payload(int len);
        t_byte_q p;
        int      pick;
        while (p.size() < len) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                p = {p, CH_D, CH_L, CH_E, CH_D, CH_L, CH_E};
            end else if (pick < 50) begin
                case ($urandom_range(0, 4))
                    0: p.push_back(CH_D);
                    1: p.push_back(CH_L);
                    2: p.push_back(CH_E);
                    3: p.push_back(CH_T);
                    default: p.push_back(CH_X);
                endcase
            end else begin
                p.push_back(8'($urandom_range(0, 255)));
            end
        end
        return p;
    endfunction

    // A cut frame stops after 'where' bytes with a stream end; a bad marker
    // frame stops at marker byte number 'where' with a wrong byte in its place.
    function automatic void add_frame(t_byte_q pay, t_frame_fault fault, int where,
                                      logic drain);
        t_byte_q fr;
        int      cut;
        fr = {CH_S, CH_Y, CH_N, CH_S, CH_Y, CH_N, CH_S, CH_O, CH_H};
        repeat (HDR_BYTES) fr.push_back(8'($urandom_range(0, 255)));
        fr = {fr, CH_S, CH_T, CH_X};
        foreach (pay[i]) begin
            fr.push_back(pay[i]);
        end
        fr = {fr, CH_E, CH_T, CH_X, 8'($urandom_range(0, 255))};
        case (fault)
            FRAME_WHOLE:      cut = fr.size();
            FRAME_CUT:        cut = (where > fr.size()) ? fr.size() : where;
            default:          cut = (where < 9) ? where : HDR_BYTES + where;
        endcase
        for (int i = 0; i < cut; i++) begin
            queue_item(fr[i], 1'b0, drain && i == 0);
        end
        if (fault == FRAME_CUT) begin
            queue_item(8'($urandom_range(0, 255)), 1'b1, drain && cut == 0);
        end else if (fault == FRAME_BAD_MARKER) begin
            queue_item(fr[cut] ^ 8'($urandom_range(1, 255)), 1'b0, drain && cut == 0);
        end
    endfunction

    function automatic logic idle_roll(int progress);
        return (progress < 150 || progress >= 270) && ($urandom_range(0, 99) < 34);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued bytes, holding each until it is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                deframe_byte(i_in_byte, i_stream_end);
                sent_count++;
            end
            if (!i_valid || o_ready) begin
                if (rx_stream_q.size() > 0 && !idle_roll(sent_count)
                        && !(rx_stream_q[0].wait_drain && frame_results_q.size() != 0)) begin
                    next_item = rx_stream_q.pop_front();
                    i_valid      <= 1'b1;
                    i_in_byte    <= next_item.value;
                    i_stream_end <= next_item.stream_end;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result against the oldest expected one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                seen_count++;
                if (frame_results_q.size() == 0) begin
                    $error("unexpected result: kind %0d data %02h status %0d last %0d",
                           o_kind, o_data, o_status, o_last);
                    fail_count++;
                end else begin
                    want = frame_results_q.pop_front();
                    if (o_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, o_kind);
                        fail_count++;
                    end
                    if (o_data !== want.data) begin
                        $error("data: expected %02h, got %02h", want.data, o_data);
                        fail_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        fail_count++;
                    end
                end
            end
            i_ready <= !idle_roll(seen_count);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        t_byte_q pay;
        int      pick;
        logic    drain;

        // Short directed part: byte extremes, idle stream end, and a break
        // in each of the three opening markers.
        queue_item(8'h00, 1'b0, 1'b0);
        queue_item(8'hFF, 1'b0, 1'b0);
        queue_item(8'hFF, 1'b1, 1'b0);
        queue_item(CH_S, 1'b0, 1'b0);
        queue_item(CH_Y, 1'b0, 1'b0);
        queue_item(CH_X, 1'b0, 1'b0);
        pay = {CH_S, CH_Y, CH_N, CH_S, 8'h51};
        foreach (pay[i]) queue_item(pay[i], 1'b0, 1'b0);
        pay = {CH_S, CH_Y, CH_N, CH_S, CH_Y, CH_N, CH_S, CH_O, 8'h41};
        foreach (pay[i]) queue_item(pay[i], 1'b0, 1'b0);
        pay = {CH_S, CH_Y, CH_N};
        foreach (pay[i]) queue_item(pay[i], 1'b0, 1'b0);
        queue_item(8'h00, 1'b1, 1'b0);

        // Whole frame with stuffed, broken-stuffed and near-ETX payload.
        pay = {CH_D, CH_L, CH_E, CH_D, CH_L, CH_E, CH_D, CH_L, CH_E, CH_D, CH_L, CH_S,
               CH_E, CH_E, CH_T, CH_E, CH_T, CH_T, CH_D, CH_L, CH_E, CH_E};
        add_frame(pay, FRAME_WHOLE, 0, 1'b1);
        // Stream end with five bytes held for unstuffing and two as a
        // possible ETX: the largest burst one request can release.
        pay = {CH_D, CH_L, CH_E, CH_D, CH_L, CH_E, CH_T};
        add_frame(pay, FRAME_CUT, HDR_BYTES + 12 + pay.size(), 1'b0);
        add_frame(rand_payload(4), FRAME_BAD_MARKER, 11, 1'b0);
        add_frame(rand_payload(6), FRAME_CUT, $urandom_range(10, HDR_BYTES + 8), 1'b1);
        pay = rand_payload(3);
        add_frame(pay, FRAME_CUT, HDR_BYTES + 15 + pay.size(), 1'b0);

        while (rx_stream_q.size() < RUN_ITEMS) begin
            pick  = $urandom_range(0, 99);
            drain = ($urandom_range(0, 29) == 0);
            if (pick < 45) begin
                add_frame(rand_payload($urandom_range(0, 24)), FRAME_WHOLE, 0, drain);
            end else if (pick < 60) begin
                add_frame(rand_payload($urandom_range(0, 24)), FRAME_CUT,
                          $urandom_range(0, HDR_BYTES + 40), drain);
            end else if (pick < 70) begin
                add_frame(rand_payload($urandom_range(0, 8)), FRAME_BAD_MARKER,
                          $urandom_range(0, 11), drain);
            end else if (pick < 90) begin
                // Noise leaning on marker letters so partial matches occur.
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0: queue_item(CH_S, 1'b0, 1'b0);
                        1: queue_item(CH_Y, 1'b0, 1'b0);
                        2: queue_item(CH_N, 1'b0, 1'b0);
                        default: queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    endcase
                end
            end else begin
                queue_item(8'($urandom_range(0, 255)), 1'b1, drain);
            end
        end
        total_items = rx_stream_q.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((sent_count < total_items || frame_results_q.size() != 0)
                && cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);

        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout: %0d of %0d requests sent, %0d results outstanding",
                     sent_count, total_items, frame_results_q.size());
            $display("testbench failed");
        end else begin
            $display("Sent %0d requests and checked %0d results in %0d cycles.",
                     sent_count, seen_count, cycle_count);
            $display("Frames closed %0d, truncated streams %0d, marker errors %0d.",
                     frames_closed, truncations, marker_errors);
            if (fail_count == 0) begin
                $display("testbench passed");
            end else begin
                $display("testbench failed");
            end
        end
        $finish;
    end

endmodule
